FILE: hw/rtl/irn_pkg.sv
// irn_pkg: shared types and constants for the roman numeral converter
// no dependencies

package irn_pkg;

    localparam int NumWidth    = 12;
    localparam int LetterWidth = 8;
    localparam int NumPairs    = 13;

    localparam logic [NumWidth-1:0] LimitValue = 12'd3999;

    localparam logic [LetterWidth-1:0] LetterNone = 8'h00;
    localparam logic [LetterWidth-1:0] LetterI    = 8'h49;
    localparam logic [LetterWidth-1:0] LetterV    = 8'h56;
    localparam logic [LetterWidth-1:0] LetterX    = 8'h58;
    localparam logic [LetterWidth-1:0] LetterL    = 8'h4C;
    localparam logic [LetterWidth-1:0] LetterC    = 8'h43;
    localparam logic [LetterWidth-1:0] LetterD    = 8'h44;
    localparam logic [LetterWidth-1:0] LetterM    = 8'h4D;

    localparam logic [NumWidth-1:0] PairValue [NumPairs] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };

    localparam logic [LetterWidth-1:0] PairFirst [NumPairs] = '{
        LetterM, LetterC, LetterD, LetterC, LetterC, LetterX, LetterL,
        LetterX, LetterX, LetterI, LetterV, LetterI, LetterI
    };

    localparam logic [LetterWidth-1:0] PairSecond [NumPairs] = '{
        LetterNone, LetterM, LetterNone, LetterD, LetterNone, LetterC, LetterNone,
        LetterL, LetterNone, LetterX, LetterNone, LetterV, LetterNone
    };

    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic item_last;
    } t_status;

endpackage

FILE: hw/rtl/irn_if.sv
// irn_in_if / irn_out_if: valid-ready channels for numbers and letters
// depends on irn_pkg

interface irn_in_if;
    logic                          valid;
    logic                          ready;
    logic [irn_pkg::NumWidth-1:0]  number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface irn_out_if;
    logic                            valid;
    logic                            ready;
    logic [irn_pkg::LetterWidth-1:0] letter;
    logic                            last;
    logic                            empty_res;
    logic                            out_of_range;

    modport source (output valid, output letter, output last, output empty_res,
                    output out_of_range, input ready);
    modport sink   (input valid, input letter, input last, input empty_res,
                    input out_of_range, output ready);
endinterface

FILE: hw/rtl/integer_to_roman_numeral.sv
// integer_to_roman_numeral: number in, one roman letter per output transaction
// the number is loaded into the remainder register when accepted; the first letter is then
// registered by a sequencer step once the output register is free; one letter per cycle, while the
// output is not stalled, from the remainder register and table compare; errors and zero give one item
// reset: synchronous active low, clears sequencer state and output valid
// depends on irn_pkg, irn_if, irn_ctrl, irn_datapath

module integer_to_roman_numeral (
    input  logic              i_clk,
    input  logic              i_rst_n,
    irn_in_if.sink            i_in,
    irn_out_if.source         o_out
);

    irn_pkg::t_cmd    cmd;
    irn_pkg::t_status status;

    irn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    irn_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_number       (i_in.number),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_letter       (o_out.letter),
        .o_last         (o_out.last),
        .o_empty_res    (o_out.empty_res),
        .o_out_of_range (o_out.out_of_range)
    );

endmodule

FILE: hw/rtl/irn_datapath.sv
// irn_datapath: remainder register, greedy pair selection, output register
// depends on irn_pkg

module irn_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  irn_pkg::t_cmd                   i_cmd,
    output irn_pkg::t_status                o_status,
    input  logic [irn_pkg::NumWidth-1:0]    i_number,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [irn_pkg::LetterWidth-1:0] o_letter,
    output logic                            o_last,
    output logic                            o_empty_res,
    output logic                            o_out_of_range
);

    logic [irn_pkg::NumWidth-1:0]    r_num, n_num;
    logic [irn_pkg::LetterWidth-1:0] r_pend, n_pend;
    logic                            r_first;
    logic                            r_valid;
    logic [irn_pkg::LetterWidth-1:0] r_letter, n_letter;
    logic                            r_last, n_last;
    logic                            r_empty, n_empty;
    logic                            r_oor, n_oor;

    logic [irn_pkg::NumWidth-1:0]    sel_value;
    logic [irn_pkg::LetterWidth-1:0] sel_first;
    logic [irn_pkg::LetterWidth-1:0] sel_second;
    logic [irn_pkg::NumWidth-1:0]    rem;

    // largest table value not above the remainder
    always_comb begin
        sel_value  = irn_pkg::PairValue[irn_pkg::NumPairs-1];
        sel_first  = irn_pkg::PairFirst[irn_pkg::NumPairs-1];
        sel_second = irn_pkg::PairSecond[irn_pkg::NumPairs-1];
        for (int i = irn_pkg::NumPairs - 1; i >= 0; i--) begin
            if (r_num >= irn_pkg::PairValue[i]) begin
                sel_value  = irn_pkg::PairValue[i];
                sel_first  = irn_pkg::PairFirst[i];
                sel_second = irn_pkg::PairSecond[i];
            end
        end
    end

    assign rem = r_num - sel_value;

    always_comb begin
        n_num    = r_num;
        n_pend   = irn_pkg::LetterNone;
        n_letter = irn_pkg::LetterNone;
        n_last   = 1'b1;
        n_empty  = 1'b0;
        n_oor    = 1'b0;
        priority if (r_pend != irn_pkg::LetterNone) begin
            n_letter = r_pend;
            n_last   = (r_num == '0);
        end else if (r_first && (r_num > irn_pkg::LimitValue)) begin
            n_oor = 1'b1;
        end else if (r_first && (r_num == '0)) begin
            n_empty = 1'b1;
        end else begin
            n_letter = sel_first;
            n_pend   = sel_second;
            n_num    = rem;
            n_last   = (sel_second == irn_pkg::LetterNone) && (rem == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num   <= i_number;
            r_pend  <= irn_pkg::LetterNone;
            r_first <= 1'b1;
        end else if (i_cmd.step) begin
            r_num   <= n_num;
            r_pend  <= n_pend;
            r_first <= 1'b0;
        end
        if (i_cmd.step) begin
            r_letter <= n_letter;
            r_last   <= n_last;
            r_empty  <= n_empty;
            r_oor    <= n_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.step) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_status.out_free  = !r_valid || i_out_ready;
    assign o_status.item_last = n_last;

    assign o_out_valid    = r_valid;
    assign o_letter       = r_letter;
    assign o_last         = r_last;
    assign o_empty_res    = r_empty;
    assign o_out_of_range = r_oor;

endmodule

FILE: hw/rtl/irn_ctrl.sv
// irn_ctrl: sequencer that loads a number and steps out its letters
// depends on irn_pkg

module irn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  irn_pkg::t_status i_status,
    output irn_pkg::t_cmd    o_cmd
);

    localparam logic StIdle = 1'b0;
    localparam logic StEmit = 1'b1;

    logic r_state, n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.step = 1'b0;
        o_in_ready = 1'b0;
        unique case (r_state)
            StIdle: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = StEmit;
                end
            end
            StEmit: begin
                if (i_status.out_free) begin
                    o_cmd.step = 1'b1;
                    if (i_status.item_last) begin
                        n_state = StIdle;
                    end
                end
            end
            default: n_state = StIdle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: hw/rtl/irn_checker.sv
// irn_checker: port-level checks for integer_to_roman_numeral, with bind
// depends on irn_pkg

module irn_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [irn_pkg::LetterWidth-1:0] i_letter,
    input logic                            i_last,
    input logic                            i_empty_res,
    input logic                            i_out_of_range
);

    // stalled transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_letter) && $stable(i_last))
        else $error("output transaction changed while stalled");

    a_oor_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_of_range |->
            i_last && !i_empty_res && (i_letter == irn_pkg::LetterNone))
        else $error("out of range item malformed");

    a_empty_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_empty_res |-> i_last && (i_letter == irn_pkg::LetterNone))
        else $error("empty item malformed");

    a_letter_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_empty_res && !i_out_of_range |->
            (i_letter != irn_pkg::LetterNone))
        else $error("letter item without letter");

    // one number at a time
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("number accepted while still converting");

endmodule

bind integer_to_roman_numeral irn_checker u_irn_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_letter       (o_out.letter),
    .i_last         (o_out.last),
    .i_empty_res    (o_out.empty_res),
    .i_out_of_range (o_out.out_of_range)
);

FILE: sim/integer_to_roman_numeral_tb.sv
// integer_to_roman_numeral_tb: directed and random numbers into the roman numeral
// converter, every letter transaction checked against a local greedy predictor
// depends on irn_pkg, irn_if and integer_to_roman_numeral

module integer_to_roman_numeral_tb;

    localparam int StallLimit = 5000;
    localparam int TailCycles = 40;

    localparam logic [irn_pkg::NumWidth-1:0] StepValue [irn_pkg::NumPairs] = '{
        12'd1000, 12'd900, 12'd500, 12'd400, 12'd100, 12'd90, 12'd50,
        12'd40, 12'd10, 12'd9, 12'd5, 12'd4, 12'd1
    };
    localparam logic [irn_pkg::LetterWidth-1:0] StepHead [irn_pkg::NumPairs] = '{
        irn_pkg::LetterM, irn_pkg::LetterC, irn_pkg::LetterD, irn_pkg::LetterC,
        irn_pkg::LetterC, irn_pkg::LetterX, irn_pkg::LetterL, irn_pkg::LetterX,
        irn_pkg::LetterX, irn_pkg::LetterI, irn_pkg::LetterV, irn_pkg::LetterI,
        irn_pkg::LetterI
    };
    localparam logic [irn_pkg::LetterWidth-1:0] StepTail [irn_pkg::NumPairs] = '{
        irn_pkg::LetterNone, irn_pkg::LetterM, irn_pkg::LetterNone, irn_pkg::LetterD,
        irn_pkg::LetterNone, irn_pkg::LetterC, irn_pkg::LetterNone, irn_pkg::LetterL,
        irn_pkg::LetterNone, irn_pkg::LetterX, irn_pkg::LetterNone, irn_pkg::LetterV,
        irn_pkg::LetterNone
    };

    typedef struct packed {
        logic [irn_pkg::LetterWidth-1:0] letter;
        logic                            last;
        logic                            empty_res;
        logic                            out_of_range;
    } t_letter_item;

    logic i_clk;
    logic i_rst_n;
    bit   no_stall;
    int   error_count;
    int   quiet_cycles;

    t_letter_item pending_letters[$];

    irn_in_if  u_in ();
    irn_out_if u_out ();

    integer_to_roman_numeral u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (u_in),
        .o_out   (u_out)
    );

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        u_in.valid   = 1'b0;
        u_in.number  = '0;
        u_out.ready  = 1'b0;
        no_stall     = 1'b0;
        error_count  = 0;
        quiet_cycles = 0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic bit stall_now();
        return !no_stall && ($urandom_range(99) < 34);
    endfunction

    function automatic void predict_numeral(input logic [irn_pkg::NumWidth-1:0] value);
        logic [irn_pkg::NumWidth-1:0]    rest;
        logic [irn_pkg::LetterWidth-1:0] chars[$];
        if (value > irn_pkg::LimitValue) begin
            pending_letters.push_back('{irn_pkg::LetterNone, 1'b1, 1'b0, 1'b1});
        end else if (value == '0) begin
            pending_letters.push_back('{irn_pkg::LetterNone, 1'b1, 1'b1, 1'b0});
        end else begin
            rest = value;
            for (int i = 0; i < irn_pkg::NumPairs; i++) begin
                while (rest >= StepValue[i]) begin
                    chars.push_back(StepHead[i]);
                    if (StepTail[i] != irn_pkg::LetterNone) chars.push_back(StepTail[i]);
                    rest = rest - StepValue[i];
                end
            end
            foreach (chars[k]) begin
                pending_letters.push_back('{chars[k], k == chars.size() - 1, 1'b0, 1'b0});
            end
        end
    endfunction

    // returns at the rising edge where the transaction is taken, valid left high
    task automatic send_number(input logic [irn_pkg::NumWidth-1:0] value);
        while (stall_now()) begin
            u_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        u_in.valid  <= 1'b1;
        u_in.number <= value;
        @(negedge i_clk);
        while (!u_in.ready) @(negedge i_clk);
        predict_numeral(value);
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        u_out.ready <= !stall_now();
    end

    always @(negedge i_clk) begin
        t_letter_item got;
        t_letter_item want;
        if (i_rst_n && u_out.valid && u_out.ready) begin
            got = '{u_out.letter, u_out.last, u_out.empty_res, u_out.out_of_range};
            if (pending_letters.size() == 0) begin
                error_count++;
                $display("%0t unexpected transaction: expected none, got %h/%b/%b/%b",
                         $time, got.letter, got.last, got.empty_res, got.out_of_range);
            end else begin
                want = pending_letters.pop_front();
                if (got !== want) begin
                    error_count++;
                    $display("%0t mismatch: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                             $time, want.letter, want.last, want.empty_res,
                             want.out_of_range, got.letter, got.last, got.empty_res,
                             got.out_of_range);
                end
            end
        end
    end

    // watchdog on cycles with no transaction on either channel
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if ((u_in.valid && u_in.ready) || (u_out.valid && u_out.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= StallLimit) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    task automatic test_directed();
        logic [irn_pkg::NumWidth-1:0] values[$];
        values = '{12'd0, 12'd1, 12'd4, 12'd5, 12'd9, 12'd10, 12'd40, 12'd50, 12'd90,
                   12'd100, 12'd400, 12'd500, 12'd900, 12'd1000, 12'd1994, 12'd3888,
                   12'd3999, 12'd4000, 12'd4095, 12'd2048, 12'h555, 12'haaa};
        foreach (values[i]) send_number(values[i]);
    endtask

    task automatic test_random_in_range();
        for (int i = 0; i < 140; i++) begin
            no_stall = (i >= 60 && i < 100);
            send_number(12'($urandom_range(3999, 1)));
        end
        no_stall = 1'b0;
    endtask

    task automatic test_random_full_range();
        int pick;
        for (int i = 0; i < 40; i++) begin
            pick = $urandom_range(9);
            if (pick == 0) send_number('0);
            else if (pick == 1) send_number(12'($urandom_range(4095, 4000)));
            else send_number(12'($urandom_range(4095, 0)));
        end
    endtask

    task automatic test_back_to_back();
        no_stall = 1'b1;
        for (int i = 0; i < 30; i++) begin
            send_number(12'($urandom_range(4095, 0)));
        end
        no_stall = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_in_range();
        test_random_full_range();
        test_back_to_back();
        u_in.valid <= 1'b0;
        while (pending_letters.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
        if (error_count == 0 && pending_letters.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
